### src/rbgf_pkg.sv
`timescale 1ns / 1ps

package rbgf_pkg;

  // Default depth of the line stores (samples per raw row at most)
  localparam int MaxLineDef = 8192;

  // Configuration port geometry
  localparam int AddrW = 5;
  localparam int DataW = 32;

  // Reset values of the configuration registers
  localparam logic [1:0]  ModeRst      = 2'd1;
  localparam logic [13:0] LineWidthRst = 14'd8192;
  localparam logic [12:0] CropLeftRst  = 13'd0;
  localparam logic [15:0] CropTopRst   = 16'd0;
  localparam logic [13:0] CropWidthRst = 14'd8192;
  localparam logic [15:0] CropHgtRst   = 16'd65535;

  // Filter selection; the unused code behaves as pass-through
  typedef enum logic [1:0] {
    MODE_BOX   = 2'd0,
    MODE_BINOM = 2'd1,
    MODE_PASS  = 2'd2
  } mode_e;

  // Register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_FILTER_MODE = 3'd0,
    REG_LINE_WIDTH  = 3'd1,
    REG_CROP_LEFT   = 3'd2,
    REG_CROP_TOP    = 3'd3,
    REG_CROP_WIDTH  = 3'd4,
    REG_CROP_HEIGHT = 3'd5
  } reg_e;

  typedef struct packed {
    logic [1:0]  filter_mode;
    logic [13:0] raw_line_width;
    logic [12:0] crop_left;
    logic [15:0] crop_top;
    logic [13:0] crop_width;
    logic [15:0] crop_height;
  } cfg_t;

  typedef struct packed {
    logic [15:0] raw_sample;
    logic        frame_start;
  } in_word_t;

  typedef struct packed {
    logic [15:0] gray_value;
    logic [12:0] out_col;
    logic [15:0] out_row;
    logic [15:0] min_gray;
    logic [15:0] max_gray;
    logic        frame_last;
  } out_word_t;

endpackage

### src/raw_binomial_gray_filter_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake                   Payload
// input     in_valid_i / in_ready_o     in_word_i  (raw_sample, frame_start)
// output    out_valid_o / out_ready_i   out_word_o (gray, col, row, min, max, last)
// config    psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// One sample word per clock while in_ready_o is high. A word that yields a pixel passes
// the stage 1, stage 2 and output registers (line store read, kernel, extremes/output).
// Both line stores share one memory with one write and one read port; a read
// and write of the same column in one cycle is forwarded.
// Reset clears counters, window, extremes and config; the line store is not cleared.
// A stalled output holds the last stage; earlier stages keep moving until full.

module raw_binomial_gray_filter_unit #(
  parameter int MaxLine = rbgf_pkg::MaxLineDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rbgf_pkg::in_word_t         in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rbgf_pkg::out_word_t        out_word_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbgf_pkg::AddrW-1:0] paddr,
  input  logic [rbgf_pkg::DataW-1:0] pwdata,
  output logic [rbgf_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  import rbgf_pkg::*;

  localparam int ColW = $clog2(MaxLine);
  localparam int XW   = ((ColW > 13) ? ColW : 13) + 1;

  cfg_t cfg;

  rbgf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Effective line width, clamped to [2, MaxLine]
  logic [ColW:0] line_w;
  always_comb begin
    if (cfg.raw_line_width < 14'd2) begin
      line_w = (ColW + 1)'(2);
    end else if (32'(cfg.raw_line_width) > MaxLine) begin
      line_w = (ColW + 1)'(MaxLine);
    end else begin
      line_w = (ColW + 1)'(cfg.raw_line_width);
    end
  end

  // ---------------------------------------------------------------- stage 0
  logic            accept;
  logic [ColW-1:0] col_q, col_d, c0;
  logic [15:0]     row_q, row_d, r0;
  logic            ovf_q, ovf_d, ovf0;
  logic [ColW:0]   c0_inc;
  logic            s1_v_q;
  logic            s1_adv;

  assign in_ready_o = !s1_v_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  // Position of the incoming word; frame start restarts at column 0, row 0
  always_comb begin
    c0     = in_word_i.frame_start ? '0 : col_q;
    r0     = in_word_i.frame_start ? '0 : row_q;
    ovf0   = in_word_i.frame_start ? 1'b0 : ovf_q;
    c0_inc = {1'b0, c0} + 1'b1;
    col_d  = c0_inc[ColW-1:0];
    row_d  = r0;
    ovf_d  = ovf0;
    if (c0_inc >= line_w) begin
      col_d = '0;
      if (r0 == 16'hFFFF) begin
        ovf_d = 1'b1;
      end else begin
        row_d = r0 + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ovf_q <= 1'b0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      ovf_q <= ovf_d;
    end
  end

  // Line store: upper row in the high half, lower row in the low half
  logic            ram_we;
  logic [ColW-1:0] ram_waddr;
  logic [31:0]     ram_wdata, ram_rdata;

  rbgf_ram #(
    .Width (32),
    .Depth (MaxLine)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (c0),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- stage 1
  logic [15:0]     s1_sample_q;
  logic [ColW-1:0] s1_c_q;
  logic [15:0]     s1_r_q;
  logic            s1_fs_q;
  logic            s1_act_q;
  logic            s1_fwd_q;
  logic [31:0]     s1_fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q   <= in_word_i.raw_sample;
      s1_c_q        <= c0;
      s1_r_q        <= r0;
      s1_fs_q       <= in_word_i.frame_start;
      s1_act_q      <= !ovf0 && ({1'b0, c0} < line_w);
      // same column written by stage 1 this cycle: take its data
      s1_fwd_q      <= s1_adv && (s1_c_q == c0);
      s1_fwd_data_q <= ram_wdata;
    end
  end

  // Window: [0..2] column c-1 rows r-2..r, [3..5] column c-2
  logic [15:0] win_q [6];
  logic [15:0] top, mid, bot;

  assign top = s1_fwd_q ? s1_fwd_data_q[31:16] : ram_rdata[31:16];
  assign mid = s1_fwd_q ? s1_fwd_data_q[15:0]  : ram_rdata[15:0];
  assign bot = s1_sample_q;

  assign ram_we    = s1_adv;
  assign ram_waddr = s1_c_q;
  assign ram_wdata = {mid, s1_sample_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= top;
      win_q[1] <= mid;
      win_q[2] <= bot;
    end
  end

  // Kernel sums
  logic [17:0] box_sum;
  logic [19:0] bin_sum;

  always_comb begin
    box_sum = 18'(win_q[1]) + 18'(mid) + 18'(win_q[2]) + 18'(bot);
    bin_sum = 20'(win_q[3]) + {3'b0, win_q[0], 1'b0} + 20'(top)
            + {3'b0, win_q[4], 1'b0} + {2'b0, win_q[1], 2'b0} + {3'b0, mid, 1'b0}
            + 20'(win_q[5]) + {3'b0, win_q[2], 1'b0} + 20'(bot);
  end

  // Mode select, window position and crop test
  logic            pos_ok;
  logic [15:0]     gray1;
  logic [ColW-1:0] x1;
  logic [15:0]     y1;
  logic [XW-1:0]   x_ext, x_diff;
  logic [16:0]     y_diff;
  logic            emit1, keep1;

  always_comb begin
    pos_ok = 1'b0;
    gray1  = bot;
    x1     = s1_c_q;
    y1     = s1_r_q;
    unique case (mode_e'(cfg.filter_mode))
      MODE_BOX: begin
        pos_ok = (s1_c_q != '0) && (s1_r_q != '0);
        gray1  = box_sum[17:2];
        x1     = s1_c_q - 1'b1;
        y1     = s1_r_q - 16'd1;
      end
      MODE_BINOM: begin
        pos_ok = (s1_c_q >= ColW'(2)) && (s1_r_q >= 16'd2);
        gray1  = bin_sum[19:4];
        x1     = s1_c_q - 1'b1;
        y1     = s1_r_q - 16'd1;
      end
      default: begin
        pos_ok = 1'b1;
      end
    endcase
    x_ext  = XW'(x1);
    x_diff = x_ext - XW'(cfg.crop_left);
    y_diff = {1'b0, y1} - {1'b0, cfg.crop_top};
    emit1  = s1_act_q && pos_ok
          && (x_ext >= XW'(cfg.crop_left)) && (x_diff < XW'(cfg.crop_width))
          && (y1 >= cfg.crop_top) && (y_diff[15:0] < cfg.crop_height);
    keep1  = emit1 || s1_fs_q;
  end

  // ---------------------------------------------------------------- stage 2
  logic        s2_v_q, s2_emit_q, s2_fs_q;
  logic [15:0] s2_gray_q, s2_orow_q;
  logic [13:0] s2_oc_q;
  logic        s2_adv, s2_load;
  logic        out_v_q;

  assign s2_adv  = s2_v_q && (!s2_emit_q || !out_v_q || out_ready_i);
  assign s1_adv  = s1_v_q && (!keep1 || !s2_v_q || s2_adv);
  assign s2_load = s1_adv && keep1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_load) begin
      s2_v_q <= 1'b1;
    end else if (s2_adv) begin
      s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_emit_q <= emit1;
      s2_fs_q   <= s1_fs_q;
      s2_gray_q <= gray1;
      s2_oc_q   <= x_diff[13:0];
      s2_orow_q <= y_diff[15:0];
    end
  end

  // Running extremes; frame start reloads them before this word's pixel
  logic [15:0] min_q, max_q, min_base, max_base, min_d, max_d;
  logic        last2;

  always_comb begin
    min_base = s2_fs_q ? 16'hFFFF : min_q;
    max_base = s2_fs_q ? 16'h0000 : max_q;
    min_d    = min_base;
    max_d    = max_base;
    if (s2_emit_q) begin
      if (s2_gray_q < min_base) min_d = s2_gray_q;
      if (s2_gray_q > max_base) max_d = s2_gray_q;
    end
    last2 = (s2_oc_q == cfg.crop_width - 14'd1)
         && (s2_orow_q == cfg.crop_height - 16'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= 16'hFFFF;
      max_q <= 16'h0000;
    end else if (s2_adv) begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // ---------------------------------------------------------------- output word
  out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s2_adv && s2_emit_q) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s2_emit_q) begin
      out_q.gray_value <= s2_gray_q;
      out_q.out_col    <= s2_oc_q[12:0];
      out_q.out_row    <= s2_orow_q;
      out_q.min_gray   <= min_d;
      out_q.max_gray   <= max_d;
      out_q.frame_last <= last2;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule

### src/rbgf_ram.sv
`timescale 1ns / 1ps

module rbgf_ram #(
  parameter int Width = 32,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/rbgf_regs.sv
`timescale 1ns / 1ps

module rbgf_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbgf_pkg::AddrW-1:0] paddr,
  input  logic [rbgf_pkg::DataW-1:0] pwdata,
  output logic [rbgf_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output rbgf_pkg::cfg_t             cfg_o
);

  import rbgf_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e idx;
  logic wr_en;

  assign idx    = reg_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FILTER_MODE: cfg_d.filter_mode    = pwdata[1:0];
        REG_LINE_WIDTH:  cfg_d.raw_line_width = pwdata[13:0];
        REG_CROP_LEFT:   cfg_d.crop_left      = pwdata[12:0];
        REG_CROP_TOP:    cfg_d.crop_top       = pwdata[15:0];
        REG_CROP_WIDTH:  cfg_d.crop_width     = pwdata[13:0];
        REG_CROP_HEIGHT: cfg_d.crop_height    = pwdata[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_mode    <= ModeRst;
      cfg_q.raw_line_width <= LineWidthRst;
      cfg_q.crop_left      <= CropLeftRst;
      cfg_q.crop_top       <= CropTopRst;
      cfg_q.crop_width     <= CropWidthRst;
      cfg_q.crop_height    <= CropHgtRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read decode
  always_comb begin
    unique case (idx)
      REG_FILTER_MODE: prdata = DataW'(cfg_q.filter_mode);
      REG_LINE_WIDTH:  prdata = DataW'(cfg_q.raw_line_width);
      REG_CROP_LEFT:   prdata = DataW'(cfg_q.crop_left);
      REG_CROP_TOP:    prdata = DataW'(cfg_q.crop_top);
      REG_CROP_WIDTH:  prdata = DataW'(cfg_q.crop_width);
      REG_CROP_HEIGHT: prdata = DataW'(cfg_q.crop_height);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
